[hdl/tcl_pkg.sv]
// Shared types and constants for the tile cache LRU block.
package tcl_pkg;

  // Width of the result slot field.
  localparam int SLOT_W = 4;

  // Request modes.
  localparam logic [1:0] MODE_ENSURE = 2'd0;
  localparam logic [1:0] MODE_FILL   = 2'd1;
  localparam logic [1:0] MODE_DRAW   = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;     // latch the incoming request
    logic look;        // register the tag compare vector
    logic decide;      // form the result and settle the hit/free indexes
    logic scan_start;  // begin the oldest-stamp scan
    logic alloc_free;  // claim the first unused slot
    logic alloc_best;  // claim the slot found by the scan
    logic touch;       // restamp the matched slot
    logic fill;        // record a fill outcome
    logic out_load;    // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       hit;
    logic       present;
    logic       any_free;
    logic       scan_done;
  } stat_t;

endpackage

[hdl/tcl_datapath.sv]
// Tag store, stamp memory, oldest-stamp scan and result registers.
module tcl_datapath #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tcl_pkg::cmd_t            cmd,
  output tcl_pkg::stat_t           stat,
  input  logic [1:0]               mode,
  input  logic [4:0]               zoom,
  input  logic [29:0]              tile_x,
  input  logic [29:0]              tile_y,
  input  logic [3:0]               fill_slot,
  input  logic                     fill_ok,
  output logic                     hit,
  output logic [tcl_pkg::SLOT_W-1:0] slot,
  output logic                     need_fill,
  output logic                     drawable
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // Captured request.
  logic [1:0]  req_mode;
  logic [4:0]  req_zoom;
  logic [29:0] req_x;
  logic [29:0] req_y;
  logic [3:0]  req_fslot;
  logic        req_ok;

  // Tag store.
  logic [SLOT_COUNT-1:0] used;
  logic [SLOT_COUNT-1:0] present;
  logic [4:0]            entry_zoom [SLOT_COUNT];
  logic [29:0]           entry_col  [SLOT_COUNT];
  logic [29:0]           entry_row  [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] match_vec;

  // Stamp memory and counter.
  logic [31:0] stamp_mem [SLOT_COUNT];
  logic [31:0] stamp_counter;
  logic [31:0] stamp_next;

  // Scan state.
  logic             scan_on;
  logic [IDX_W-1:0] scan_idx;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_data;
  logic [31:0]      best_stamp;
  logic [IDX_W-1:0] best_idx;

  // Pending result.
  logic                       res_hit;
  logic [tcl_pkg::SLOT_W-1:0] res_slot;
  logic                       res_need;
  logic                       res_draw;

  logic [SLOT_COUNT-1:0] match_now;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      free_idx;
  logic                  any_hit;
  logic                  any_free;
  logic                  hit_present;
  logic [IDX_W-1:0]      victim_idx;
  logic [IDX_W-1:0]      touch_idx;
  logic [IDX_W-1:0]      fill_idx;
  logic                  fill_en;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      match_now[i] = used[i] && (entry_zoom[i] == req_zoom) &&
                     (entry_col[i] == req_x) && (entry_row[i] == req_y);
    end
  end

  // Priority encoders, lowest index wins.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!used[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit     = |match_vec;
  assign any_free    = ~&used;
  assign hit_present = |(match_vec & present);
  assign stamp_next  = stamp_counter + 32'd1;
  assign victim_idx  = cmd.alloc_best ? best_idx : free_idx;
  assign touch_idx   = cmd.touch ? hit_idx : victim_idx;
  assign fill_idx    = IDX_W'(req_fslot);
  assign fill_en     = (32'(req_fslot) < 32'(SLOT_COUNT)) && used[fill_idx];

  assign stat.mode      = req_mode;
  assign stat.hit       = any_hit;
  assign stat.present   = hit_present;
  assign stat.any_free  = any_free;
  assign stat.scan_done = rd_vld && (rd_idx == LAST_IDX);

  // Request capture, compare and result formation.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_mode  <= mode;
      req_zoom  <= zoom;
      req_x     <= tile_x;
      req_y     <= tile_y;
      req_fslot <= fill_slot;
      req_ok    <= fill_ok;
    end
    if (cmd.look) begin
      match_vec <= match_now;
    end
    if (cmd.decide) begin
      res_hit  <= ((req_mode == tcl_pkg::MODE_ENSURE) || (req_mode == tcl_pkg::MODE_DRAW)) &&
                  any_hit;
      res_need <= (req_mode == tcl_pkg::MODE_ENSURE) && !any_hit;
      res_draw <= (req_mode == tcl_pkg::MODE_DRAW) && any_hit && hit_present;
      unique case (req_mode)
        tcl_pkg::MODE_ENSURE: begin
          res_slot <= any_hit ? tcl_pkg::SLOT_W'(hit_idx) : tcl_pkg::SLOT_W'(free_idx);
        end
        tcl_pkg::MODE_FILL: begin
          res_slot <= req_fslot;
        end
        tcl_pkg::MODE_DRAW: begin
          res_slot <= any_hit ? tcl_pkg::SLOT_W'(hit_idx) : '0;
        end
        default: begin
          res_slot <= '0;
        end
      endcase
    end else if (cmd.alloc_best) begin
      res_slot <= tcl_pkg::SLOT_W'(best_idx);
    end
    if (cmd.out_load) begin
      hit       <= res_hit;
      slot      <= res_slot;
      need_fill <= res_need;
      drawable  <= res_draw;
    end
  end

  // Tag payload: write the claimed slot.
  always_ff @(posedge clk) begin
    if (cmd.alloc_free || cmd.alloc_best) begin
      entry_zoom[victim_idx] <= req_zoom;
      entry_col[victim_idx]  <= req_x;
      entry_row[victim_idx]  <= req_y;
    end
  end

  // Valid and present marks, stamp counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      used          <= '0;
      present       <= '0;
      stamp_counter <= '0;
    end else begin
      if (cmd.alloc_free || cmd.alloc_best) begin
        used[victim_idx]    <= 1'b1;
        present[victim_idx] <= 1'b0;
        stamp_counter       <= stamp_next;
      end else if (cmd.touch) begin
        stamp_counter <= stamp_next;
      end else if (cmd.fill && fill_en) begin
        present[fill_idx] <= req_ok;
      end
    end
  end

  // Stamp memory: one write port, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (cmd.alloc_free || cmd.alloc_best || cmd.touch) begin
      stamp_mem[touch_idx] <= stamp_next;
    end
    rd_data <= stamp_mem[scan_idx];
  end

  // Oldest-stamp scan, ascending so ties keep the lowest index.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_on  <= 1'b0;
      scan_idx <= '0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= scan_on;
      rd_idx <= scan_idx;
      if (cmd.scan_start) begin
        scan_on  <= 1'b1;
        scan_idx <= '0;
      end else if (scan_on) begin
        if (scan_idx == LAST_IDX) begin
          scan_on <= 1'b0;
        end else begin
          scan_idx <= scan_idx + 1'b1;
        end
      end
      if (rd_vld && ((rd_idx == '0) || (rd_data < best_stamp))) begin
        best_stamp <= rd_data;
        best_idx   <= rd_idx;
      end
    end
  end

endmodule

[hdl/tcl_ctrl.sv]
// Sequencing state machine for the tile cache LRU block.
module tcl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  tcl_pkg::stat_t stat,
  output tcl_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_DECIDE,
    S_SCAN,
    S_ALLOC,
    S_RESP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = S_RESP;
        unique case (stat.mode)
          tcl_pkg::MODE_ENSURE: begin
            if (!stat.hit) begin
              if (stat.any_free) begin
                cmd.alloc_free = 1'b1;
              end else begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
              end
            end
          end
          tcl_pkg::MODE_FILL: begin
            cmd.fill = 1'b1;
          end
          tcl_pkg::MODE_DRAW: begin
            cmd.touch = stat.hit && stat.present;
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          state_next = S_ALLOC;
        end
      end
      S_ALLOC: begin
        cmd.alloc_best = 1'b1;
        state_next     = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/tile_cache_lru_top.sv]
// Top level of the tile cache LRU block: controller, datapath and checks.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------------------------
//  request | in_valid  | in_stall  | mode, zoom, tile_x, tile_y, fill_slot, fill_ok
//  result  | out_valid | out_stall | hit, slot, need_fill, drawable
//
// One transaction in gives exactly one transaction out. A lookup hit, fill report,
// draw or ensure miss with a free slot passes from acceptance to the result register
// through these steps: accept, tag compare, decide and write-back, hand off to the output.
// An ensure miss with every slot used adds a walk of the stamp memory through its
// single read port, one slot a cycle, before the allocation.
// Reset (rst, synchronous) clears the used and present marks and the stamp counter
// at once; the block is then idle and ready to take a request.
// A stalled result sits in the output register while the next request is accepted
// and worked on; that request then holds in the hand-off step until the result is taken.
module tile_cache_lru_top #(
  parameter int SLOT_COUNT = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 mode,
  input  logic [4:0]                 zoom,
  input  logic [29:0]                tile_x,
  input  logic [29:0]                tile_y,
  input  logic [3:0]                 fill_slot,
  input  logic                       fill_ok,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       hit,
  output logic [tcl_pkg::SLOT_W-1:0] slot,
  output logic                       need_fill,
  output logic                       drawable
);

  // Command and status between the sequencer and the tag store.
  tcl_pkg::cmd_t  cmd;
  tcl_pkg::stat_t stat;

  // Sequence each request: compare, decide, optional scan, allocate, hand off.
  tcl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Hold tags, marks, stamps and the result register.
  tcl_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (mode),
    .zoom      (zoom),
    .tile_x    (tile_x),
    .tile_y    (tile_y),
    .fill_slot (fill_slot),
    .fill_ok   (fill_ok),
    .hit       (hit),
    .slot      (slot),
    .need_fill (need_fill),
    .drawable  (drawable)
  );

`ifndef SYNTHESIS
  // A claimed slot is never also reported as a hit.
  a_fill_not_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(hit && need_fill))
    else $error("result reports both hit and need_fill");

  // Drawable only for a matched entry.
  a_draw_needs_hit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && drawable) |-> hit)
    else $error("drawable without hit");

  // One request at a time: after acceptance the input side stalls.
  a_stall_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in flight");

  // A result can only appear after the request was worked on.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a request in flight");
`endif

endmodule
